// ===== rtl/fct_pkg.sv =====
`default_nettype none

package fct_pkg;

  // Frustum geometry.
  localparam int NUM_PLANES = 6;
  localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int COEFS_PER_PLANE = 4;
  localparam int AXES = 3;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int INDEX_W = 3;
  localparam int COEF_W = 32;
  localparam int POS_W = 32;
  localparam int EXT_W = 31;
  localparam int SCALE_W = 4;
  localparam int FRAC_BITS = 16;

  // Saturation width of box corner coordinates.
  localparam int COORD_W = 32;

  // Internal widths.
  localparam int SIZE_W = (EXT_W - 1) + SCALE_W;
  localparam int EXTRA_W = EXT_W + SCALE_W;
  localparam int CSUM_W = SIZE_W + 2;
  localparam int PROD_W = COEF_W + POS_W;
  localparam int ACC_W = PROD_W + 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(5);

  localparam logic signed [CSUM_W-1:0] COORD_MAX =
    CSUM_W'((longint'(1) << (COORD_W - 1)) - longint'(1));
  localparam logic signed [CSUM_W-1:0] COORD_MIN = ~COORD_MAX;

  // Coefficient slots within one plane.
  localparam logic [1:0] COEF_SEL_D = 2'd3;
  localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SPHERE = 2'd1,
    ACT_BOX    = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CORNER,
    ST_INIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic       capture;
    logic       box_item;
    logic       size_en;
    logic       corner_en;
    logic       init_en;
    logic       mul_lo_en;
    logic       mul_hi_en;
    logic       acc_en;
    logic [1:0] axis;
  } ctrl_t;

  // Clamp a corner coordinate to the signed coordinate range.
  function automatic logic signed [POS_W-1:0] sat_coord(input logic signed [CSUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[POS_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/frustum_cull_tester_unit.sv =====
// A sphere or box test runs a size and a corner step, then per plane visited (1 to 6;
// a rejection stops early) an init step, a low and a high multiply and an accumulate
// per axis, and a check; the finish step loads its result. One test runs at a time on
// the single shared 32x32 term multiplier; plane loads take one per cycle while idle.
// Reset: synchronous, active high; clears all planes to zero and sets size_scale to 5.
`default_nettype none

module frustum_cull_tester_unit
  import fct_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [SCALE_W-1:0]       cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ACTION_W-1:0]      action,
  input  wire logic [INDEX_W-1:0]       plane_index,
  input  wire logic signed [COEF_W-1:0] coef_a,
  input  wire logic signed [COEF_W-1:0] coef_b,
  input  wire logic signed [COEF_W-1:0] coef_c,
  input  wire logic signed [COEF_W-1:0] coef_d,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic signed [POS_W-1:0]  pos_z,
  input  wire logic [EXT_W-1:0]         extent_x,
  input  wire logic [EXT_W-1:0]         extent_y,
  input  wire logic [EXT_W-1:0]         extent_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          visible
);

  logic [SCALE_W-1:0]       size_scale;
  ctrl_t                    ctrl;
  logic                     store_we;
  logic [PLANE_W-1:0]       rd_plane;
  logic [1:0]               rd_sel;
  logic signed [COEF_W-1:0] coef;
  logic                     acc_neg;

  // Size scale register; every configuration transfer is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_scale <= SCALE_RESET;
    end else if (cfg_valid) begin
      size_scale <= cfg_data;
    end
  end

  fct_plane_store u_store (
    .clk      (clk),
    .rst      (rst),
    .we       (store_we),
    .wr_plane (plane_index[PLANE_W-1:0]),
    .wr_a     (coef_a),
    .wr_b     (coef_b),
    .wr_c     (coef_c),
    .wr_d     (coef_d),
    .rd_plane (rd_plane),
    .rd_sel   (rd_sel),
    .rd_data  (coef)
  );

  fct_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .action      (action),
    .plane_index (plane_index),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .visible     (visible),
    .acc_neg     (acc_neg),
    .ctrl        (ctrl),
    .store_we    (store_we),
    .rd_plane    (rd_plane),
    .rd_sel      (rd_sel)
  );

  fct_datapath u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .scale    (size_scale),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .extent_x (extent_x),
    .extent_y (extent_y),
    .extent_z (extent_z),
    .coef     (coef),
    .acc_neg  (acc_neg)
  );

endmodule

`default_nettype wire

// ===== rtl/fct_plane_store.sv =====
`default_nettype none

module fct_plane_store
  import fct_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [PLANE_W-1:0]       wr_plane,
  input  wire logic signed [COEF_W-1:0] wr_a,
  input  wire logic signed [COEF_W-1:0] wr_b,
  input  wire logic signed [COEF_W-1:0] wr_c,
  input  wire logic signed [COEF_W-1:0] wr_d,
  input  wire logic [PLANE_W-1:0]       rd_plane,
  input  wire logic [1:0]               rd_sel,
  output logic signed [COEF_W-1:0]      rd_data
);

  logic signed [COEF_W-1:0] coefs [NUM_PLANES][COEFS_PER_PLANE];

  // Plane coefficients; reset clears all planes so every test passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < COEFS_PER_PLANE; k++) begin
          coefs[p][k] <= '0;
        end
      end
    end else if (we) begin
      coefs[wr_plane][0] <= wr_a;
      coefs[wr_plane][1] <= wr_b;
      coefs[wr_plane][2] <= wr_c;
      coefs[wr_plane][3] <= wr_d;
    end
  end

  // One coefficient is read at a time by the sequencer.
  assign rd_data = coefs[rd_plane][rd_sel];

endmodule

`default_nettype wire

// ===== rtl/fct_datapath.sv =====
`default_nettype none

module fct_datapath
  import fct_pkg::*;
(
  input  wire logic                     clk,
  input  wire ctrl_t                    ctrl,
  input  wire logic [SCALE_W-1:0]       scale,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic signed [POS_W-1:0]  pos_z,
  input  wire logic [EXT_W-1:0]         extent_x,
  input  wire logic [EXT_W-1:0]         extent_y,
  input  wire logic [EXT_W-1:0]         extent_z,
  input  wire logic signed [COEF_W-1:0] coef,
  output logic                          acc_neg
);

  logic signed [POS_W-1:0]  pos_q [AXES];
  logic [EXT_W-1:0]         ext_q [AXES];
  logic                     box_q;
  logic [SIZE_W-1:0]        size_q [AXES];
  logic [EXTRA_W-1:0]       extra_q;
  logic signed [POS_W-1:0]  corner_lo [AXES];
  logic signed [POS_W-1:0]  corner_hi [AXES];
  logic signed [CSUM_W-1:0] sum_lo [AXES];
  logic signed [CSUM_W-1:0] sum_hi [AXES];
  logic signed [POS_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [PROD_W-1:0] best;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         extra_term;

  // Item capture at the input transfer.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      pos_q[0] <= pos_x;
      pos_q[1] <= pos_y;
      pos_q[2] <= pos_z;
      ext_q[0] <= extent_x;
      ext_q[1] <= extent_y;
      ext_q[2] <= extent_z;
      box_q    <= ctrl.box_item;
    end
  end

  // Scaled half sizes and the scaled sphere radius.
  always_ff @(posedge clk) begin
    if (ctrl.size_en) begin
      for (int i = 0; i < AXES; i++) begin
        size_q[i] <= SIZE_W'(ext_q[i][EXT_W-1:1]) * SIZE_W'(scale);
      end
      extra_q <= EXTRA_W'(ext_q[0]) * EXTRA_W'(scale);
    end
  end

  // Corner coordinates; a sphere uses its position on both sides.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sum_lo[i] = CSUM_W'(pos_q[i]) - $signed({2'b00, size_q[i]});
      sum_hi[i] = CSUM_W'(pos_q[i]) + $signed({2'b00, size_q[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.corner_en) begin
      for (int i = 0; i < AXES; i++) begin
        corner_lo[i] <= box_q ? sat_coord(sum_lo[i]) : pos_q[i];
        corner_hi[i] <= box_q ? sat_coord(sum_hi[i]) : pos_q[i];
      end
    end
  end

  // Shared signed multiplier: one coefficient times one corner coordinate.
  assign mul_b = ctrl.mul_hi_en ? corner_hi[ctrl.axis] : corner_lo[ctrl.axis];
  assign prod  = PROD_W'(coef) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (ctrl.mul_lo_en) begin
      prod_lo <= prod;
    end
    if (ctrl.mul_hi_en) begin
      prod_hi <= prod;
    end
  end

  // The nearest-to-inside corner takes the larger term on each axis.
  assign best = (prod_hi > prod_lo) ? prod_hi : prod_lo;
  assign extra_term = box_q ? '0 : (ACC_W'(extra_q) << FRAC_BITS);

  // Plane value accumulator, full width so it never overflows.
  always_ff @(posedge clk) begin
    if (ctrl.init_en) begin
      acc <= (ACC_W'(coef) <<< FRAC_BITS) + $signed(extra_term);
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(best);
    end
  end

  assign acc_neg = acc[ACC_W-1];

endmodule

`default_nettype wire

// ===== rtl/fct_sequencer.sv =====
`default_nettype none

module fct_sequencer
  import fct_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [INDEX_W-1:0]  plane_index,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     visible,
  input  wire logic                acc_neg,
  output ctrl_t                    ctrl,
  output logic                     store_we,
  output logic [PLANE_W-1:0]       rd_plane,
  output logic [1:0]               rd_sel
);

  state_t             state, state_next;
  logic [PLANE_W-1:0] plane, plane_next;
  logic [1:0]         axis, axis_next;
  logic               verdict, verdict_next;
  logic               in_xfer;
  logic               out_load;

  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  // Next state and loop counters.
  always_comb begin
    state_next   = state;
    plane_next   = plane;
    axis_next    = axis;
    verdict_next = verdict;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_SPHERE, ACT_BOX: state_next = ST_SIZE;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_SIZE: begin
        state_next = ST_CORNER;
      end
      ST_CORNER: begin
        state_next = ST_INIT;
        plane_next = '0;
      end
      ST_INIT: begin
        state_next = ST_MUL_LO;
        axis_next  = '0;
      end
      ST_MUL_LO: begin
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (axis == AXIS_LAST) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_MUL_LO;
          axis_next  = axis + 2'd1;
        end
      end
      ST_CHECK: begin
        if (acc_neg) begin
          verdict_next = 1'b0;
          state_next   = ST_FINISH;
        end else if (plane == PLANE_W'(NUM_PLANES - 1)) begin
          verdict_next = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          plane_next = plane + PLANE_W'(1);
          state_next = ST_INIT;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs for the datapath and the plane store.
  always_comb begin
    in_ready      = (state == ST_IDLE);
    ctrl          = '0;
    ctrl.axis     = axis;
    ctrl.box_item = (action == ACT_BOX);
    store_we      = 1'b0;
    rd_plane      = plane;
    rd_sel        = axis;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_LOAD:            store_we = ({1'b0, plane_index} < (INDEX_W + 1)'(NUM_PLANES));
            ACT_SPHERE, ACT_BOX: ctrl.capture = 1'b1;
            default:             ctrl.capture = 1'b0;
          endcase
        end
      end
      ST_SIZE:   ctrl.size_en = 1'b1;
      ST_CORNER: ctrl.corner_en = 1'b1;
      ST_INIT: begin
        ctrl.init_en = 1'b1;
        rd_sel       = COEF_SEL_D;
      end
      ST_MUL_LO: ctrl.mul_lo_en = 1'b1;
      ST_MUL_HI: ctrl.mul_hi_en = 1'b1;
      ST_ACC:    ctrl.acc_en = 1'b1;
      default:   ctrl.capture = 1'b0;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      plane   <= '0;
      axis    <= '0;
      verdict <= 1'b1;
    end else begin
      state   <= state_next;
      plane   <= plane_next;
      axis    <= axis_next;
      verdict <= verdict_next;
    end
  end

  // Output register; it holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      visible <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_test_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (action == ACT_SPHERE || action == ACT_BOX) |=> !in_ready)
    else $error("input still ready after a test transfer");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && action == ACT_LOAD && !out_valid |=> !out_valid)
    else $error("plane load produced a result");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared outside the finish step");

  a_plane_in_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> {1'b0, plane} < (PLANE_W + 1)'(NUM_PLANES))
    else $error("plane counter out of range");

  a_axis_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> axis == 2'd0 || axis == 2'd1 || axis == AXIS_LAST)
    else $error("axis counter out of range");
`endif

endmodule

`default_nettype wire
